/* rtl/frm_pkg.sv */
package frm_pkg;

    localparam int DVD_W = 74;
    localparam int DSR_W = 49;
    localparam int CNT_W = 7;

    localparam logic [31:0] CNT_MAX    = 32'hFFFF_FFFF;
    localparam logic [19:0] FPS_MAX    = 20'd1000000;
    localparam logic [17:0] RATE_SCALE = 18'd200000;
    localparam logic [9:0]  IV_RESET   = 10'd16;

    localparam logic ADDR_THRESHOLD = 1'b0;
    localparam logic ADDR_INTERVAL  = 1'b1;

    localparam logic FUNC_START = 1'b0;

    typedef logic [DVD_W-1:0] t_dvd;
    typedef logic [DSR_W-1:0] t_dsr;

    typedef struct packed {
        logic        func;
        logic [47:0] timestamp_ms;
    } t_in;

    typedef struct packed {
        logic        report_valid;
        logic [19:0] report_fps_x100;
        logic [31:0] report_max_dropped;
        logic [19:0] overall_fps_x100;
        logic [55:0] avg_frame_time_q8;
        logic [47:0] max_frame_time;
        logic [31:0] max_dropped_frames;
        logic [31:0] frame_count;
    } t_out;

    typedef struct packed {
        logic start;
        t_dvd dividend;
        t_dsr divisor;
    } t_div_req;

    // 2 * frames * 100000 + span, to be divided by 2 * span
    function automatic t_dvd rate_num(logic [31:0] frames, logic [47:0] span);
        return t_dvd'(frames) * t_dvd'(RATE_SCALE) + t_dvd'(span);
    endfunction

    function automatic logic [19:0] sat_fps(t_dvd q);
        return (q > t_dvd'(FPS_MAX)) ? FPS_MAX : q[19:0];
    endfunction

endpackage

/* rtl/frm_div.sv */
module frm_div import frm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output logic     o_done,
    output t_dvd     o_quot
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_dvd             r_dvd;
    t_dsr             r_rem;
    t_dsr             r_dsr;

    logic [DSR_W:0]   w_sh;
    logic [DSR_W:0]   w_diff;
    logic             w_ge;

    // one quotient bit per cycle; quotient bits shift in behind the dividend
    assign w_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge   = w_sh >= {1'b0, r_dsr};
    assign w_diff = w_sh - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_req.dividend;
                r_dsr  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_dvd <= {r_dvd[DVD_W-2:0], w_ge};
                r_rem <= w_ge ? w_diff[DSR_W-1:0] : w_sh[DSR_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W-1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

/* rtl/frame_rate_monitor_core.sv */
// Frame pacing monitor. A frame-end transaction updates the frame time, dropped-frame,
// session and overall statistics, a frame-start one records the frame's start time, and one
// result transaction follows each input. A start may recompute the overall rate and the
// average frame time; an end may need up to four quotients (dropped frames, session rate,
// overall rate, average frame time), which go one after another through a single restoring
// divider that yields one quotient bit per cycle of a 74-bit quotient. One transaction is
// processed at a time; a finished result waits in the output register while the next
// input is taken.
module frame_rate_monitor_core import frm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_DROP_W, S_REP_W, S_OVR, S_OVR_W, S_AVG, S_AVG_W, S_OUT
    } t_state;

    t_state      r_state;
    logic [31:0] r_thr;
    logic [9:0]  r_iv;

    logic        r_func;
    logic [47:0] r_t;
    logic        r_first;
    logic [47:0] r_fst;
    logic [47:0] r_lst;
    logic [47:0] r_let;
    logic [47:0] r_sst;
    logic [31:0] r_sfr;
    logic [31:0] r_smd;
    logic [31:0] r_tot;
    logic [63:0] r_sum;
    logic [47:0] r_longest;
    logic [31:0] r_most;

    logic        r_rvalid;
    logic [19:0] r_rfps;
    logic [31:0] r_rdrop;
    logic [19:0] r_ovr;
    logic [55:0] r_avg;

    logic        r_out_valid;
    t_out        r_out;
    t_div_req    r_div;

    logic        w_done;
    t_dvd        w_quot;
    logic [47:0] w_ft;
    logic [64:0] w_sum;
    logic [31:0] w_drop;
    logic [31:0] w_smd;
    logic [47:0] w_span;
    logic        w_report;

    frm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_div),
        .o_done (w_done),
        .o_quot (w_quot)
    );

    assign w_ft     = (r_t >= r_lst) ? r_t - r_lst : '0;
    assign w_sum    = {1'b0, r_sum} + {17'd0, w_ft};
    assign w_drop   = (w_quot > t_dvd'(CNT_MAX)) ? CNT_MAX : w_quot[31:0];
    assign w_smd    = (w_drop > r_smd) ? w_drop : r_smd;
    assign w_span   = r_t - r_sst;
    assign w_report = (r_thr != '0) && (r_t >= r_sst) && (w_span > 48'(r_thr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_iv  <= IV_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                ADDR_THRESHOLD: r_thr <= pwdata;
                ADDR_INTERVAL:  r_iv  <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == ADDR_INTERVAL) ? {22'd0, r_iv} : r_thr;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div.start <= 1'b0;
            r_first     <= 1'b0;
            r_fst       <= '0;
            r_lst       <= '0;
            r_let       <= '0;
            r_sst       <= '0;
            r_sfr       <= '0;
            r_smd       <= '0;
            r_tot       <= '0;
            r_sum       <= '0;
            r_longest   <= '0;
            r_most      <= '0;
        end else begin
            // S_OUT reloads the output register itself
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_func  <= i_in_data.func;
                        r_t     <= i_in_data.timestamp_ms;
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    r_rvalid    <= 1'b0;
                    r_rfps      <= '0;
                    r_rdrop     <= '0;
                    r_div.start <= (r_func != FUNC_START);
                    if (r_func == FUNC_START) begin
                        if (!r_first) begin
                            r_first <= 1'b1;
                            r_fst   <= r_t;
                            r_sst   <= r_t;
                            r_sfr   <= '0;
                            r_smd   <= '0;
                        end
                        r_lst   <= r_t;
                        r_state <= S_OVR;
                    end else begin
                        r_let <= r_t;
                        if (w_ft > r_longest) begin
                            r_longest <= w_ft;
                        end
                        if (r_tot != CNT_MAX) begin
                            r_sum <= w_sum[64] ? '1 : w_sum[63:0];
                            r_tot <= r_tot + 1'b1;
                        end
                        if (r_sfr != CNT_MAX) begin
                            r_sfr <= r_sfr + 1'b1;
                        end
                        r_div.dividend <= t_dvd'(w_ft);
                        r_div.divisor  <= t_dsr'((r_iv == '0) ? 10'd1 : r_iv);
                        r_state        <= S_DROP_W;
                    end
                end
                S_DROP_W: begin
                    r_div.start <= w_done && w_report && (r_sst != '0);
                    if (w_done) begin
                        if (w_drop > r_most) begin
                            r_most <= w_drop;
                        end
                        if (w_report) begin
                            r_rvalid <= 1'b1;
                            r_rdrop  <= w_smd;
                            r_sst    <= r_t;
                            r_sfr    <= '0;
                            r_smd    <= '0;
                            if (r_sst != '0) begin
                                r_div.dividend <= rate_num(r_sfr, w_span);
                                r_div.divisor  <= {w_span, 1'b0};
                                r_state        <= S_REP_W;
                            end else begin
                                r_state <= S_OVR;
                            end
                        end else begin
                            r_smd   <= w_smd;
                            r_state <= S_OVR;
                        end
                    end
                end
                S_REP_W: begin
                    r_div.start <= 1'b0;
                    if (w_done) begin
                        r_rfps  <= sat_fps(w_quot);
                        r_state <= S_OVR;
                    end
                end
                S_OVR: begin
                    r_div.start <= r_first && (r_let > r_fst);
                    if (r_first && (r_let > r_fst)) begin
                        r_div.dividend <= rate_num(r_tot, r_let - r_fst);
                        r_div.divisor  <= {r_let - r_fst, 1'b0};
                        r_state        <= S_OVR_W;
                    end else begin
                        r_ovr   <= '0;
                        r_state <= S_AVG;
                    end
                end
                S_OVR_W: begin
                    r_div.start <= 1'b0;
                    if (w_done) begin
                        r_ovr   <= sat_fps(w_quot);
                        r_state <= S_AVG;
                    end
                end
                S_AVG: begin
                    // (512 * sum + n) / (2 * n) gives the rounded q8 average
                    r_div.start <= (r_tot != '0);
                    if (r_tot != '0) begin
                        r_div.dividend <= {1'b0, r_sum, 9'd0} + t_dvd'(r_tot);
                        r_div.divisor  <= t_dsr'({r_tot, 1'b0});
                        r_state        <= S_AVG_W;
                    end else begin
                        r_avg   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_AVG_W: begin
                    r_div.start <= 1'b0;
                    if (w_done) begin
                        r_avg   <= w_quot[55:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out.report_valid       <= r_rvalid;
                        r_out.report_fps_x100    <= r_rfps;
                        r_out.report_max_dropped <= r_rdrop;
                        r_out.overall_fps_x100   <= r_ovr;
                        r_out.avg_frame_time_q8  <= r_avg;
                        r_out.max_frame_time     <= r_longest;
                        r_out.max_dropped_frames <= r_most;
                        r_out.frame_count        <= r_tot;
                        r_out_valid              <= 1'b1;
                        r_state                  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
